### rtl/core/lipp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lipp_pkg: shared types and per-channel helpers of the inverse pixel predictor
// Holds the predictor mode codes, pixel geometry and the byte-wise arithmetic
// used to form a prediction from the neighbouring ARGB pixels.
// ----------------------------------------------------------------------------
package lipp_pkg;

  localparam int PIX_W  = 32;
  localparam int CH_W   = 8;
  localparam int NUM_CH = PIX_W / CH_W;

  localparam logic [PIX_W-1:0] BLACK_ARGB = 32'hFF00_0000;

  typedef logic [PIX_W-1:0] pix_t;
  typedef logic [CH_W-1:0]  ch_t;

  // predictor rule codes; the two unused codes predict opaque black
  typedef enum logic [3:0] {
    PRED_BLACK      = 4'd0,
    PRED_L          = 4'd1,
    PRED_T          = 4'd2,
    PRED_TR         = 4'd3,
    PRED_TL         = 4'd4,
    PRED_AVG_LTR_T  = 4'd5,
    PRED_AVG_L_TL   = 4'd6,
    PRED_AVG_L_T    = 4'd7,
    PRED_AVG_TL_T   = 4'd8,
    PRED_AVG_T_TR   = 4'd9,
    PRED_AVG_4      = 4'd10,
    PRED_SELECT     = 4'd11,
    PRED_CLAMP_FULL = 4'd12,
    PRED_CLAMP_HALF = 4'd13
  } mode_t;

  // floor average of two channel values
  function automatic ch_t avg_ch(input ch_t a, input ch_t b);
    logic [CH_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[CH_W:1];
  endfunction

  // floor average channel by channel
  function automatic pix_t avg_px(input pix_t a, input pix_t b);
    pix_t r;
    for (int i = 0; i < NUM_CH; i++) begin
      r[i*CH_W +: CH_W] = avg_ch(a[i*CH_W +: CH_W], b[i*CH_W +: CH_W]);
    end
    return r;
  endfunction

  // absolute difference of two channel values
  function automatic ch_t absdiff_ch(input ch_t a, input ch_t b);
    ch_t r;
    r = (a > b) ? (a - b) : (b - a);
    return r;
  endfunction

  // saturate a 10-bit signed value to 0..255
  function automatic ch_t sat_ch(input logic signed [CH_W+1:0] v);
    ch_t r;
    if (v[CH_W+1]) begin
      r = '0;
    end else if (v[CH_W]) begin
      r = '1;
    end else begin
      r = v[CH_W-1:0];
    end
    return r;
  endfunction

  // clamp(l + t - tl)
  function automatic ch_t clamp_full_ch(input ch_t l, input ch_t t, input ch_t tl);
    logic signed [CH_W+1:0] v;
    v = signed'({2'b00, l}) + signed'({2'b00, t}) - signed'({2'b00, tl});
    return sat_ch(v);
  endfunction

  // clamp(a + (a - tl) / 2), halving truncates toward zero
  function automatic ch_t clamp_half_ch(input ch_t a, input ch_t tl);
    logic signed [CH_W+1:0] d;
    logic signed [CH_W+1:0] half;
    logic signed [CH_W+1:0] v;
    d    = signed'({2'b00, a}) - signed'({2'b00, tl});
    half = (d + signed'({{(CH_W+1){1'b0}}, d[CH_W+1]})) >>> 1;
    v    = signed'({2'b00, a}) + half;
    return sat_ch(v);
  endfunction

endpackage

`default_nettype wire

### rtl/core/lipp_predict.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lipp_predict: prediction and residual add for one pixel
// Forms the prediction selected by the mode from the left, top-left, top and
// top-right neighbours, then adds the residual per channel modulo 256.
// ----------------------------------------------------------------------------
module lipp_predict (
  input  wire logic [3:0]          mode,
  input  wire lipp_pkg::pix_t      residual,
  input  wire lipp_pkg::pix_t      left,
  input  wire lipp_pkg::pix_t      top_left,
  input  wire lipp_pkg::pix_t      top,
  input  wire lipp_pkg::pix_t      top_right,
  output lipp_pkg::pix_t           pixel
);

  lipp_pkg::pix_t pred;
  lipp_pkg::pix_t avg_l_tr;
  lipp_pkg::pix_t avg_l_tl;
  lipp_pkg::pix_t avg_t_tr;
  lipp_pkg::pix_t avg_l_t;
  lipp_pkg::pix_t clamp_full;
  lipp_pkg::pix_t clamp_half;
  logic [lipp_pkg::CH_W+1:0] grad_l;
  logic [lipp_pkg::CH_W+1:0] grad_t;

  // averages; all but avg_l_tr feed more than one rule
  assign avg_l_tr = lipp_pkg::avg_px(left, top_right);
  assign avg_l_tl = lipp_pkg::avg_px(left, top_left);
  assign avg_t_tr = lipp_pkg::avg_px(top, top_right);
  assign avg_l_t  = lipp_pkg::avg_px(left, top);

  // gradient sums for the select rule and the clamped gradients
  always_comb begin
    grad_l = '0;
    grad_t = '0;
    for (int i = 0; i < lipp_pkg::NUM_CH; i++) begin
      grad_l = grad_l + {2'b00, lipp_pkg::absdiff_ch(top[i*lipp_pkg::CH_W +: lipp_pkg::CH_W],
                                                     top_left[i*lipp_pkg::CH_W +: lipp_pkg::CH_W])};
      grad_t = grad_t + {2'b00, lipp_pkg::absdiff_ch(left[i*lipp_pkg::CH_W +: lipp_pkg::CH_W],
                                                     top_left[i*lipp_pkg::CH_W +: lipp_pkg::CH_W])};
      clamp_full[i*lipp_pkg::CH_W +: lipp_pkg::CH_W] =
        lipp_pkg::clamp_full_ch(left[i*lipp_pkg::CH_W +: lipp_pkg::CH_W],
                                top[i*lipp_pkg::CH_W +: lipp_pkg::CH_W],
                                top_left[i*lipp_pkg::CH_W +: lipp_pkg::CH_W]);
      clamp_half[i*lipp_pkg::CH_W +: lipp_pkg::CH_W] =
        lipp_pkg::clamp_half_ch(avg_l_t[i*lipp_pkg::CH_W +: lipp_pkg::CH_W],
                                top_left[i*lipp_pkg::CH_W +: lipp_pkg::CH_W]);
    end
  end

  // rule selection
  always_comb begin
    case (lipp_pkg::mode_t'(mode))
      lipp_pkg::PRED_L:          pred = left;
      lipp_pkg::PRED_T:          pred = top;
      lipp_pkg::PRED_TR:         pred = top_right;
      lipp_pkg::PRED_TL:         pred = top_left;
      lipp_pkg::PRED_AVG_LTR_T:  pred = lipp_pkg::avg_px(avg_l_tr, top);
      lipp_pkg::PRED_AVG_L_TL:   pred = avg_l_tl;
      lipp_pkg::PRED_AVG_L_T:    pred = avg_l_t;
      lipp_pkg::PRED_AVG_TL_T:   pred = lipp_pkg::avg_px(top_left, top);
      lipp_pkg::PRED_AVG_T_TR:   pred = avg_t_tr;
      lipp_pkg::PRED_AVG_4:      pred = lipp_pkg::avg_px(avg_l_tl, avg_t_tr);
      lipp_pkg::PRED_SELECT:     pred = (grad_l < grad_t) ? left : top;
      lipp_pkg::PRED_CLAMP_FULL: pred = clamp_full;
      lipp_pkg::PRED_CLAMP_HALF: pred = clamp_half;
      default:                   pred = lipp_pkg::BLACK_ARGB;
    endcase
  end

  // residual add, carries cut at channel boundaries
  always_comb begin
    for (int i = 0; i < lipp_pkg::NUM_CH; i++) begin
      pixel[i*lipp_pkg::CH_W +: lipp_pkg::CH_W] = pred[i*lipp_pkg::CH_W +: lipp_pkg::CH_W]
                                                + residual[i*lipp_pkg::CH_W +: lipp_pkg::CH_W];
    end
  end

endmodule

`default_nettype wire

### rtl/core/lossless_inverse_pixel_predictor.sv
// data path: each input transaction loads the input register, and the result
//   register loads from it when stage 1 advances
// throughput: one pixel per cycle unless the output stalls; the left neighbour
//   feeds back from the last result through byte averages, adds and compares
// reset: synchronous, active low; clears both stage valids and sets the stored
//   left neighbour to zero
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lossless_inverse_pixel_predictor: streaming inverse lossless pixel predictor
// Registers each input transaction, rebuilds the ARGB pixel from its
// neighbours and residual, and holds it in an output register that also
// serves as the next pixel's left neighbour.
// ----------------------------------------------------------------------------
module lossless_inverse_pixel_predictor (
  input  wire logic         clk,
  input  wire logic         rst_n,
  // input stream
  input  wire logic         in_tvalid,
  output logic              in_tready,
  // residual, top_left, top, top_right, left_in (32 bits each, from bit 0 up)
  input  wire logic [159:0] in_tdata,
  // mode [3:0], load_left [4]
  input  wire logic [4:0]   in_tuser,
  input  wire logic         in_tlast,
  // result stream
  output logic              out_tvalid,
  input  wire logic         out_tready,
  // pixel [31:0]
  output logic [31:0]       out_tdata,
  output logic              out_tlast
);

  localparam int W = lipp_pkg::PIX_W;

  logic           s1_valid_r;
  logic [3:0]     s1_mode_r;
  lipp_pkg::pix_t s1_residual_r;
  lipp_pkg::pix_t s1_top_left_r;
  lipp_pkg::pix_t s1_top_r;
  lipp_pkg::pix_t s1_top_right_r;
  logic           s1_load_left_r;
  lipp_pkg::pix_t s1_left_in_r;
  logic           s1_last_r;

  logic           out_valid_r;
  logic           out_valid_nxt;
  lipp_pkg::pix_t prev_r;
  logic           out_last_r;

  logic           in_xfer;
  logic           advance;
  lipp_pkg::pix_t left;
  lipp_pkg::pix_t pixel;

  // handshake: stage 1 advances when the output register is free or drains
  assign advance   = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || advance;
  assign in_xfer   = in_tvalid && in_tready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (advance) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_mode_r      <= in_tuser[3:0];
      s1_load_left_r <= in_tuser[4];
      s1_residual_r  <= in_tdata[0*W +: W];
      s1_top_left_r  <= in_tdata[1*W +: W];
      s1_top_r       <= in_tdata[2*W +: W];
      s1_top_right_r <= in_tdata[3*W +: W];
      s1_left_in_r   <= in_tdata[4*W +: W];
      s1_last_r      <= in_tlast;
    end
  end

  // left neighbour select
  assign left = s1_load_left_r ? s1_left_in_r : prev_r;

  lipp_predict u_predict (
    .mode      (s1_mode_r),
    .residual  (s1_residual_r),
    .left      (left),
    .top_left  (s1_top_left_r),
    .top       (s1_top_r),
    .top_right (s1_top_right_r),
    .pixel     (pixel)
  );

  // output register, doubles as the stored previous pixel
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      prev_r      <= '0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (advance) begin
        prev_r <= pixel;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_last_r <= s1_last_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = prev_r;
  assign out_tlast  = out_last_r;

endmodule

`default_nettype wire

### rtl/core/lipp_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lipp_checker: port-level checks of the inverse pixel predictor
// Watches the stream ports for reset, stall and latency behavior.
// ----------------------------------------------------------------------------
module lipp_checker (
  input wire logic         clk,
  input wire logic         rst_n,
  input wire logic         in_tvalid,
  input wire logic         in_tready,
  input wire logic         out_tvalid,
  input wire logic         out_tready,
  input wire logic [31:0]  out_tdata,
  input wire logic         out_tlast
);

  // a stalled result holds its value
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("result changed while stalled");

  // no result directly after reset
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  // a draining output never blocks the input side
  a_no_bubble: assert property (@(posedge clk) disable iff (!rst_n)
    out_tready |-> in_tready)
    else $error("input stalled while output drains");

  // an accepted transaction reaches the output once stage 1 finds the output draining
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) ##1 out_tready |=> out_tvalid)
    else $error("result missing after two cycles");

endmodule

bind lossless_inverse_pixel_predictor lipp_checker u_lipp_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);

`default_nettype wire

### sim/tb_lossless_inverse_pixel_predictor.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_lossless_inverse_pixel_predictor: self-checking bench for the pixel predictor
// A short table of directed pixels covers every mode, channel extremes, clamping,
// halving toward zero and the select tie. Runs of random pixels, mostly opening
// with a loaded left neighbour, follow. A byte-wise model of the predictor tracks the left
// neighbour and queues each expected pixel for in-order comparison, while both
// stream sides idle at random and the result side stalls once for a long stretch.
// ----------------------------------------------------------------------------
module tb_lossless_inverse_pixel_predictor;

  localparam int N_DIRECTED  = 25;
  localparam int N_RANDOM    = 1825;
  localparam int HOLD_AT     = 400;
  localparam int HOLD_CYCLES = 300;
  localparam int DRAIN_WAIT  = 8;

  // codes outside the named rules, both predict opaque black
  localparam logic [3:0] MODE_SPARE_14 = 4'd14;
  localparam logic [3:0] MODE_SPARE_15 = 4'd15;

  // one input pixel; known marks a row whose result is typed in
  typedef struct packed {
    logic [3:0]     mode;
    lipp_pkg::pix_t residual;
    lipp_pkg::pix_t top_left;
    lipp_pkg::pix_t top;
    lipp_pkg::pix_t top_right;
    logic           load_left;
    lipp_pkg::pix_t left_in;
    logic           end_of_run;
    logic           known;
    lipp_pkg::pix_t known_pixel;
  } pixel_req_t;

  typedef struct packed {
    lipp_pkg::pix_t pixel;
    logic           run_last;
  } pixel_out_t;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  // residual, top_left, top, top_right, left_in (32 bits each, from bit 0 up)
  logic [159:0] in_tdata = '0;
  // mode [3:0], load_left [4]
  logic [4:0]   in_tuser = '0;
  logic         in_tlast = 1'b0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  // pixel [31:0]
  logic [31:0]  out_tdata;
  logic         out_tlast;

  // typed-in result travelling alongside the current input transaction
  logic           known_ok = 1'b0;
  lipp_pkg::pix_t known_pix = '0;

  lipp_pkg::pix_t left_pixel = '0;
  pixel_out_t     expected_pixels[$];
  int             errors = 0;
  int             sent = 0;

  // mode, residual, tl, t, tr, load_left, left_in, end_of_run, known, pixel
  pixel_req_t directed_rows [N_DIRECTED] = '{
    '{lipp_pkg::PRED_L, 32'h0, 32'h0, 32'h0, 32'h0, 1'b0, 32'h0, 1'b0,
      1'b1, 32'h0000_0000},
    '{lipp_pkg::PRED_BLACK, 32'h0, 32'h0, 32'h0, 32'h0, 1'b0, 32'h0, 1'b0,
      1'b1, 32'hFF00_0000},
    '{lipp_pkg::PRED_BLACK, 32'h01FF_FFFF, 32'h0, 32'h0, 32'h0, 1'b0, 32'h0, 1'b1,
      1'b1, 32'h00FF_FFFF},
    '{lipp_pkg::PRED_T, 32'h0101_0101, 32'h0, 32'hFFFF_FFFF, 32'h0, 1'b0, 32'h0, 1'b0,
      1'b1, 32'h0000_0000},
    '{lipp_pkg::PRED_TR, 32'h0, 32'h0, 32'h0, 32'h1234_5678, 1'b0, 32'h0, 1'b0,
      1'b1, 32'h1234_5678},
    '{lipp_pkg::PRED_TL, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0, 32'h0, 1'b0, 32'h0, 1'b0,
      1'b1, 32'hFEFE_FEFE},
    '{lipp_pkg::PRED_L, 32'h0, 32'h0, 32'h0, 32'h0, 1'b1, 32'hA5A5_A5A5, 1'b0,
      1'b1, 32'hA5A5_A5A5},
    '{lipp_pkg::PRED_L, 32'h0101_0101, 32'h0, 32'h0, 32'h0, 1'b0, 32'h0, 1'b1,
      1'b1, 32'hA6A6_A6A6},
    '{lipp_pkg::PRED_AVG_LTR_T, 32'h0, 32'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1,
      32'hFFFF_FFFF, 1'b0, 1'b1, 32'hFFFF_FFFF},
    '{lipp_pkg::PRED_AVG_L_TL, 32'h0, 32'h00FE_7F81, 32'h0, 32'h0, 1'b1, 32'h01FF_0080,
      1'b0, 1'b0, 32'h0},
    '{lipp_pkg::PRED_AVG_L_T, 32'h0301_FF00, 32'h0, 32'h8080_8080, 32'h0, 1'b0, 32'h0,
      1'b0, 1'b0, 32'h0},
    '{lipp_pkg::PRED_AVG_TL_T, 32'h0, 32'hFFFF_FFFF, 32'h0000_0001, 32'h0, 1'b0, 32'h0,
      1'b0, 1'b0, 32'h0},
    '{lipp_pkg::PRED_AVG_T_TR, 32'h8000_0001, 32'h0, 32'hFF00_FF00, 32'h0101_0101, 1'b0,
      32'h0, 1'b1, 1'b0, 32'h0},
    '{lipp_pkg::PRED_AVG_4, 32'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1,
      32'hFFFF_FFFF, 1'b0, 1'b1, 32'hFFFF_FFFF},
    '{lipp_pkg::PRED_SELECT, 32'h0, 32'h0, 32'h0000_0001, 32'h0, 1'b1, 32'h0100_0000,
      1'b0, 1'b1, 32'h0000_0001},
    '{lipp_pkg::PRED_SELECT, 32'h0, 32'h0, 32'h0000_0001, 32'h0, 1'b1, 32'h0000_0003,
      1'b0, 1'b1, 32'h0000_0003},
    '{lipp_pkg::PRED_SELECT, 32'h0, 32'h0, 32'h0000_FFFF, 32'h0, 1'b1, 32'h0000_0100,
      1'b0, 1'b1, 32'h0000_FFFF},
    '{lipp_pkg::PRED_CLAMP_FULL, 32'h0, 32'h0, 32'hFFFF_FFFF, 32'h0, 1'b1, 32'hFFFF_FFFF,
      1'b0, 1'b1, 32'hFFFF_FFFF},
    '{lipp_pkg::PRED_CLAMP_FULL, 32'h0, 32'hFFFF_FFFF, 32'h0, 32'h0, 1'b1, 32'h0,
      1'b0, 1'b1, 32'h0000_0000},
    '{lipp_pkg::PRED_CLAMP_FULL, 32'h0, 32'hFF80_0008, 32'h8001_0020, 32'h0, 1'b1,
      32'h80FF_0010, 1'b0, 1'b0, 32'h0},
    '{lipp_pkg::PRED_CLAMP_HALF, 32'h0, 32'h0D0D_0D0D, 32'h0A0A_0A0A, 32'h0, 1'b1,
      32'h0A0A_0A0A, 1'b0, 1'b1, 32'h0909_0909},
    '{lipp_pkg::PRED_CLAMP_HALF, 32'h0, 32'h0, 32'hFFFF_FFFF, 32'h0, 1'b1, 32'hFFFF_FFFF,
      1'b0, 1'b1, 32'hFFFF_FFFF},
    '{lipp_pkg::PRED_CLAMP_HALF, 32'h0, 32'hFFFF_FFFF, 32'h0, 32'h0, 1'b1, 32'h0,
      1'b1, 1'b1, 32'h0000_0000},
    '{MODE_SPARE_14, 32'h0, 32'h1111_1111, 32'h2222_2222, 32'h3333_3333, 1'b1,
      32'h4444_4444, 1'b1, 1'b1, 32'hFF00_0000},
    '{MODE_SPARE_15, 32'h00FF_FFFF, 32'h0, 32'h0, 32'h0, 1'b0, 32'h0, 1'b0,
      1'b1, 32'hFFFF_FFFF}
  };

  lossless_inverse_pixel_predictor DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast)
  );

  always #4 clk = ~clk;

  // floor average channel by channel
  function automatic lipp_pkg::pix_t avg_bytes(input lipp_pkg::pix_t a,
                                               input lipp_pkg::pix_t b);
    lipp_pkg::pix_t r;
    for (int i = 0; i < 4; i++) begin
      r[i*8 +: 8] = 8'((int'(a[i*8 +: 8]) + int'(b[i*8 +: 8])) / 2);
    end
    return r;
  endfunction

  function automatic logic [7:0] clamp_byte(input int v);
    if (v < 0) return 8'h00;
    if (v > 255) return 8'hFF;
    return 8'(v);
  endfunction

  // prediction from the neighbours, then residual added per byte
  function automatic lipp_pkg::pix_t rebuild_pixel(input logic [3:0] mode,
                                                   input lipp_pkg::pix_t l,
                                                   input lipp_pkg::pix_t tl,
                                                   input lipp_pkg::pix_t t,
                                                   input lipp_pkg::pix_t tr,
                                                   input lipp_pkg::pix_t residual);
    lipp_pkg::pix_t p;
    lipp_pkg::pix_t a;
    int   pl;
    int   pt;
    int   d;
    int   v;
    pl = 0;
    pt = 0;
    case (mode)
      lipp_pkg::PRED_L:         p = l;
      lipp_pkg::PRED_T:         p = t;
      lipp_pkg::PRED_TR:        p = tr;
      lipp_pkg::PRED_TL:        p = tl;
      lipp_pkg::PRED_AVG_LTR_T: p = avg_bytes(avg_bytes(l, tr), t);
      lipp_pkg::PRED_AVG_L_TL:  p = avg_bytes(l, tl);
      lipp_pkg::PRED_AVG_L_T:   p = avg_bytes(l, t);
      lipp_pkg::PRED_AVG_TL_T:  p = avg_bytes(tl, t);
      lipp_pkg::PRED_AVG_T_TR:  p = avg_bytes(t, tr);
      lipp_pkg::PRED_AVG_4:     p = avg_bytes(avg_bytes(l, tl), avg_bytes(t, tr));
      lipp_pkg::PRED_SELECT: begin
        for (int i = 0; i < 4; i++) begin
          d = int'(t[i*8 +: 8]) - int'(tl[i*8 +: 8]);
          pl += (d < 0) ? -d : d;
          d = int'(l[i*8 +: 8]) - int'(tl[i*8 +: 8]);
          pt += (d < 0) ? -d : d;
        end
        p = (pl < pt) ? l : t;
      end
      lipp_pkg::PRED_CLAMP_FULL: begin
        for (int i = 0; i < 4; i++) begin
          v = int'(l[i*8 +: 8]) + int'(t[i*8 +: 8]) - int'(tl[i*8 +: 8]);
          p[i*8 +: 8] = clamp_byte(v);
        end
      end
      lipp_pkg::PRED_CLAMP_HALF: begin
        a = avg_bytes(l, t);
        for (int i = 0; i < 4; i++) begin
          // int division truncates toward zero
          v = int'(a[i*8 +: 8]) + (int'(a[i*8 +: 8]) - int'(tl[i*8 +: 8])) / 2;
          p[i*8 +: 8] = clamp_byte(v);
        end
      end
      default:        p = lipp_pkg::BLACK_ARGB;
    endcase
    for (int i = 0; i < 4; i++) begin
      p[i*8 +: 8] = p[i*8 +: 8] + residual[i*8 +: 8];
    end
    return p;
  endfunction

  // random pixel, each channel biased toward its extremes and midpoint
  function automatic lipp_pkg::pix_t rand_argb();
    lipp_pkg::pix_t r;
    for (int i = 0; i < 4; i++) begin
      case ($urandom_range(0, 7))
        0:       r[i*8 +: 8] = 8'h00;
        1:       r[i*8 +: 8] = 8'hFF;
        2:       r[i*8 +: 8] = 8'h7F + 8'($urandom_range(0, 1));
        3:       r[i*8 +: 8] = ($urandom_range(0, 1) != 0) ? 8'h01 : 8'hFE;
        default: r[i*8 +: 8] = 8'($urandom);
      endcase
    end
    return r;
  endfunction

  // offer one pixel after a random gap and hold it until accepted
  task automatic send_pixel(input pixel_req_t r);
    int gap;
    gap = (((sent / 64) % 4) == 2) ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {r.left_in, r.top_right, r.top, r.top_left, r.residual};
    in_tuser  <= {r.load_left, r.mode};
    in_tlast  <= r.end_of_run;
    known_ok  <= r.known;
    known_pix <= r.known_pixel;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sent++;
  endtask

  // predict on each input transaction, compare on each output transaction
  always @(posedge clk) begin : scoreboard
    lipp_pkg::pix_t l;
    lipp_pkg::pix_t pix;
    pixel_out_t     want;
    if (rst_n && in_tvalid && in_tready) begin
      l   = in_tuser[4] ? in_tdata[159:128] : left_pixel;
      pix = rebuild_pixel(in_tuser[3:0], l, in_tdata[63:32], in_tdata[95:64],
                          in_tdata[127:96], in_tdata[31:0]);
      left_pixel = pix;
      expected_pixels.push_back('{known_ok ? known_pix : pix, in_tlast});
    end
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_pixels.size() == 0) begin
        errors++;
        $display("%0t: unexpected pixel %h last %b", $time, out_tdata, out_tlast);
      end else begin
        want = expected_pixels.pop_front();
        if (out_tdata !== want.pixel) begin
          errors++;
          $display("%0t: pixel expected %h actual %h", $time, want.pixel, out_tdata);
        end
        if (out_tlast !== want.run_last) begin
          errors++;
          $display("%0t: run_last expected %b actual %b", $time, want.run_last,
                   out_tlast);
        end
      end
    end
  end

  // result side: random stalls, quiet stretches and one long hold-off
  initial begin : result_sink
    int stall;
    int taken;
    taken = 0;
    while (!rst_n) @(posedge clk);
    forever begin
      if (taken == HOLD_AT) begin
        stall = HOLD_CYCLES;
      end else begin
        stall = (((taken / 80) % 4) == 1) ? 0 : $urandom_range(0, 5);
      end
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      @(posedge clk);
      while (!out_tvalid) @(posedge clk);
      taken++;
    end
  end

  // stimulus: directed table, then runs of random pixels
  initial begin : pixel_source
    pixel_req_t r;
    int         run_left;
    logic       run_start;
    run_left = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      send_pixel(directed_rows[i]);
    end

    for (int n = 0; n < N_RANDOM; n++) begin
      run_start = (run_left == 0);
      if (run_start) run_left = $urandom_range(1, 16);
      r.mode        = ($urandom_range(0, 31) == 0) ? 4'($urandom_range(14, 15))
                                                   : 4'($urandom_range(0, 13));
      r.residual    = rand_argb();
      r.top_left    = rand_argb();
      r.top         = rand_argb();
      r.top_right   = rand_argb();
      r.left_in     = rand_argb();
      // a run mostly opens with a loaded left neighbour, then chains
      r.load_left   = run_start ? ($urandom_range(0, 9) != 0)
                                : ($urandom_range(0, 15) == 0);
      run_left--;
      r.end_of_run  = (run_left == 0) ^ ($urandom_range(0, 19) == 0);
      r.known       = 1'b0;
      r.known_pixel = '0;
      send_pixel(r);
    end
    in_tvalid <= 1'b0;
    known_ok  <= 1'b0;

    while (expected_pixels.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // overall time limit
  initial begin
    #2_000_000;
    $display("%0t: timeout", $time);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
